[rtl/pran_pkg.sv]
// Shared constants, types and helpers for the point rotation block.
`timescale 1ns / 1ps
package pran_pkg;

  localparam int COORD_BITS = 32;          // point coordinate width, Q16.16 at 32
  localparam int CFG_W      = 16;          // normal component width, Q1.15
  localparam int CFG_IDX_W  = 3;
  localparam int MAT_W      = 18;          // matrix entry, Q2.16
  localparam int MAT_N      = 9;
  localparam int FRAC       = 16;
  localparam int Q16_ONE    = 65536;
  localparam int NZ_RST     = 32767;       // reset z of both normals

  localparam int MUL_W      = 34;          // shared builder multiplier operand
  localparam int ACC_W      = 66;          // builder accumulator
  localparam int NUM_W      = MUL_W;       // divider numerator
  localparam int SQ_W       = 64;          // square root radicand
  localparam int ROOT_W     = 32;
  localparam int SQ_ITERS   = SQ_W / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_ITERS + 1);
  localparam int DEN_W      = ROOT_W;
  localparam int DIV_QB     = 19;          // biased quotient bits
  localparam int DIV_W      = 54;
  localparam int DIV_CNT_W  = $clog2(DIV_QB + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_NX = 3'd0,
    REG_SRC_NY = 3'd1,
    REG_SRC_NZ = 3'd2,
    REG_DST_NX = 3'd3,
    REG_DST_NY = 3'd4,
    REG_DST_NZ = 3'd5
  } cfg_reg_t;

  typedef logic [MAT_N-1:0][MAT_W-1:0] mat_t;   // row major

  typedef struct packed {
    logic busy;    // matrix rebuild in progress
    logic degen;   // identity in use
  } bld_status_t;

  function automatic mat_t ident_mat();
    mat_t r;
    r = '0;
    for (int i = 0; i < 3; i++) r[4*i] = MAT_W'(Q16_ONE);
    return r;
  endfunction

endpackage

[rtl/pran_if.sv]
// Stream interfaces for input points and rotated results.
`timescale 1ns / 1ps
interface pran_pt_if;
  import pran_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface pran_res_if;
  import pran_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic degenerate;
  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

[rtl/point_rotation_align_normals.sv]
// Top level: rotates points so that a source normal lands on a target normal.
//
//  channel    dir  handshake      payload
//  points     in   valid/ready    in_x, in_y, in_z      (signed Q16.16)
//  results    out  valid/ready    out_x, out_y, out_z, degenerate
//  cfg        in   cfg_we         cfg_index, cfg_data   (normals, Q1.15)
//
//  One point per cycle while results are accepted and no rebuild is in progress.
//  A config write to a normal register rebuilds the matrix with the shared
//  multiplier, square root and divider units, or loads the identity when the
//  normals are parallel; points are held off meanwhile.
//  Reset loads the identity matrix with degenerate set.
//  A stalled result holds all stages; nothing is dropped or repeated.
`timescale 1ns / 1ps
module point_rotation_align_normals (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pran_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pran_pkg::CFG_W-1:0]      cfg_data,
  pran_pt_if.sink                         points,
  pran_res_if.source                      results
);
  import pran_pkg::*;

  mat_t        mat;      // rotation matrix, Q2.16 row major
  bld_status_t status;   // rebuild busy, degenerate flag

  // matrix builder: config registers, multiply sequence, sqrt and divide
  pran_builder u_builder (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .status    (status)
  );

  // streaming matrix-vector pipeline
  pran_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .mat     (mat),
    .status  (status),
    .points  (points),
    .results (results)
  );

endmodule

[rtl/pran_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module pran_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pran_pkg::SQ_W-1:0]    val,
  output logic                         busy,
  output logic [pran_pkg::ROOT_W-1:0]  root
);
  import pran_pkg::*;

  logic [SQ_W-1:0]     rem;
  logic [SQ_W-1:0]     res;
  logic [SQ_W-1:0]     bitv;
  logic [SQ_CNT_W-1:0] cnt;
  logic                run;
  logic [SQ_W:0]       trial;

  assign trial = {1'b0, res} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= SQ_CNT_W'(SQ_ITERS);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == SQ_CNT_W'(1)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= val;
      res  <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end else if (run) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign busy = run;
  assign root = res[ROOT_W-1:0];

endmodule

[rtl/pran_div.sv]
// Restoring divider for round-half-up Q16 quotients floor((2^17 a + b)/(2b)).
`timescale 1ns / 1ps
module pran_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [pran_pkg::NUM_W-1:0]  num,
  input  logic [pran_pkg::DEN_W-1:0]         den,
  output logic                               busy,
  output logic signed [pran_pkg::MAT_W-1:0]  quot
);
  import pran_pkg::*;

  // quotient is biased by 2^(DIV_QB-2) so the dividend stays positive
  localparam logic [DIV_QB-1:0] QBIAS = DIV_QB'(1) << (DIV_QB - 2);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dv;
  logic [DIV_QB-1:0]    q;
  logic [DIV_QB-1:0]    qd;
  logic [DIV_W-1:0]     start_rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;

  assign start_rem = (DIV_W'(num) << (FRAC + 1)) + DIV_W'(den)
                   + (DIV_W'(den) << (DIV_QB - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= DIV_CNT_W'(DIV_QB);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= start_rem;
      dv  <= DIV_W'(den) << DIV_QB;
      q   <= '0;
    end else if (run) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        q   <= {q[DIV_QB-2:0], 1'b1};
      end else begin
        q   <= {q[DIV_QB-2:0], 1'b0};
      end
      dv <= dv >> 1;
    end
  end

  assign qd   = q - QBIAS;
  assign busy = run;
  assign quot = $signed(qd[MAT_W-1:0]);

endmodule

[rtl/pran_builder.sv]
// Configuration registers and the sequencer that rebuilds the rotation matrix.
`timescale 1ns / 1ps
module pran_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pran_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pran_pkg::CFG_W-1:0]      cfg_data,
  output pran_pkg::mat_t                  mat,
  output pran_pkg::bld_status_t           status
);
  import pran_pkg::*;

  localparam int SK_W  = MAT_W + 2;
  localparam int OMC_W = MAT_W + 2;
  localparam int E_W   = MAT_W + 4;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,   // cross, dot, lengths
    ST_SQL  = 7'b0000100,   // n = sqrt(|a|^2 |b|^2)
    ST_SQU  = 7'b0001000,   // m = sqrt(|u|^2)
    ST_DIV  = 7'b0010000,   // c, s, k
    ST_SK   = 7'b0100000,   // s*k terms
    ST_MAT  = 7'b1000000    // entries
  } state_t;

  state_t state;

  logic signed [CFG_W-1:0]  a [3];
  logic signed [CFG_W-1:0]  b [3];
  logic signed [MUL_W-1:0]  u [3];
  logic signed [MUL_W-1:0]  dot;
  logic signed [MUL_W-1:0]  la;
  logic signed [MUL_W-1:0]  lb;
  logic [SQ_W-1:0]          lsq;
  logic [SQ_W-1:0]          lusq;
  logic [ROOT_W-1:0]        n;
  logic [ROOT_W-1:0]        m;
  logic signed [MAT_W-1:0]  c;
  logic signed [MAT_W-1:0]  s;
  logic signed [MAT_W-1:0]  k [3];
  logic signed [SK_W-1:0]   sk [3];
  logic signed [SK_W-1:0]   t;
  logic signed [ACC_W-1:0]  acc;
  logic degen;

  logic [4:0] pc;
  logic [2:0] dsel;
  logic [1:0] mi, mj;
  logic       mb;
  logic       launched;

  logic signed [MUL_W-1:0]   mx, my;
  logic                      clr, neg;
  logic signed [2*MUL_W-1:0] prod_full;
  logic signed [ACC_W-1:0]   prod, acc_next, rp;
  logic signed [OMC_W-1:0]   omc;
  logic [1:0]                kx, nxt;
  logic signed [E_W-1:0]     addv, ent;
  logic [3:0]                eidx;
  logic                      cfg_hit;

  logic                      sq_start, sq_busy;
  logic [SQ_W-1:0]           sq_val;
  logic [ROOT_W-1:0]         sq_root;
  logic                      dv_start, dv_busy;
  logic signed [NUM_W-1:0]   dv_num;
  logic [DEN_W-1:0]          dv_den;
  logic signed [MAT_W-1:0]   dv_quot;

  function automatic logic signed [ACC_W-1:0] rq16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] r;
    r = x + $signed(ACC_W'(1) << (FRAC - 1));
    return r >>> FRAC;
  endfunction

  function automatic logic signed [MAT_W-1:0] sat_mat(input logic signed [E_W-1:0] v);
    if (&v[E_W-1:MAT_W-1] || ~|v[E_W-1:MAT_W-1]) return v[MAT_W-1:0];
    else if (v[E_W-1]) return {1'b1, {(MAT_W-1){1'b0}}};
    else return {1'b0, {(MAT_W-1){1'b1}}};
  endfunction

  // operand selection for the shared multiplier
  always_comb begin
    mx  = '0;
    my  = '0;
    clr = 1'b0;
    neg = 1'b0;
    unique case (state)
      ST_MUL: begin
        unique case (pc)
          5'd0:  begin mx = MUL_W'(b[1]); my = MUL_W'(a[2]); clr = 1'b1; end
          5'd1:  begin mx = MUL_W'(b[2]); my = MUL_W'(a[1]); neg = 1'b1; end
          5'd2:  begin mx = MUL_W'(b[2]); my = MUL_W'(a[0]); clr = 1'b1; end
          5'd3:  begin mx = MUL_W'(b[0]); my = MUL_W'(a[2]); neg = 1'b1; end
          5'd4:  begin mx = MUL_W'(b[0]); my = MUL_W'(a[1]); clr = 1'b1; end
          5'd5:  begin mx = MUL_W'(b[1]); my = MUL_W'(a[0]); neg = 1'b1; end
          5'd6:  begin mx = MUL_W'(a[0]); my = MUL_W'(b[0]); clr = 1'b1; end
          5'd7:  begin mx = MUL_W'(a[1]); my = MUL_W'(b[1]); end
          5'd8:  begin mx = MUL_W'(a[2]); my = MUL_W'(b[2]); end
          5'd9:  begin mx = MUL_W'(a[0]); my = MUL_W'(a[0]); clr = 1'b1; end
          5'd10: begin mx = MUL_W'(a[1]); my = MUL_W'(a[1]); end
          5'd11: begin mx = MUL_W'(a[2]); my = MUL_W'(a[2]); end
          5'd12: begin mx = MUL_W'(b[0]); my = MUL_W'(b[0]); clr = 1'b1; end
          5'd13: begin mx = MUL_W'(b[1]); my = MUL_W'(b[1]); end
          5'd14: begin mx = MUL_W'(b[2]); my = MUL_W'(b[2]); end
          5'd15: begin mx = la;   my = lb;   clr = 1'b1; end
          5'd16: begin mx = u[0]; my = u[0]; clr = 1'b1; end
          5'd17: begin mx = u[1]; my = u[1]; end
          5'd18: begin mx = u[2]; my = u[2]; end
          default: ;
        endcase
      end
      ST_SK: begin
        mx = MUL_W'(s);
        my = MUL_W'(k[pc[1:0]]);
      end
      ST_MAT: begin
        if (!mb) begin
          mx = MUL_W'(k[mi]);
          my = MUL_W'(k[mj]);
        end else begin
          mx = MUL_W'(omc);
          my = MUL_W'(t);
        end
      end
      default: ;
    endcase
  end

  assign prod_full = mx * my;
  assign prod      = prod_full[ACC_W-1:0];
  assign acc_next  = (clr ? '0 : acc) + (neg ? -prod : prod);
  assign rp        = rq16(prod);
  assign omc       = $signed(OMC_W'(Q16_ONE)) - OMC_W'(c);

  // skew-symmetric term: + on (i, i+1 mod 3), - on (i, i+2 mod 3)
  always_comb begin
    kx   = 2'd0;
    nxt  = (mi == 2'd2) ? 2'd0 : mi + 2'd1;
    if (mi == mj) begin
      addv = E_W'(c);
    end else begin
      kx = 2'd3 - mi - mj;
      if (mj == nxt) addv = E_W'(sk[kx]);
      else           addv = -E_W'(sk[kx]);
    end
    ent  = $signed(rp[E_W-1:0]) + addv;
    eidx = {1'b0, mi, 1'b0} + {2'b00, mi} + {2'b00, mj};
  end

  assign cfg_hit = cfg_we && (cfg_index <= REG_DST_NZ);

  assign sq_start = (state == ST_SQL || state == ST_SQU) && !launched;
  assign sq_val   = (state == ST_SQL) ? lsq : lusq;
  assign dv_start = (state == ST_DIV) && !launched;

  always_comb begin
    dv_num = u[0];
    dv_den = m;
    unique case (dsel)
      3'd0: begin dv_num = dot; dv_den = n; end
      3'd1: begin dv_num = $signed(NUM_W'(m)); dv_den = n; end
      3'd2: dv_num = u[0];
      3'd3: dv_num = u[1];
      3'd4: dv_num = u[2];
      default: ;
    endcase
  end

  pran_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_val),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  pran_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .busy  (dv_busy),
    .quot  (dv_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a[0] <= '0; a[1] <= '0; a[2] <= CFG_W'(NZ_RST);
      b[0] <= '0; b[1] <= '0; b[2] <= CFG_W'(NZ_RST);
      mat      <= ident_mat();
      degen    <= 1'b1;
      state    <= ST_IDLE;
      pc       <= '0;
      dsel     <= '0;
      mi       <= '0;
      mj       <= '0;
      mb       <= 1'b0;
      launched <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_NX: a[0] <= cfg_data;
          REG_SRC_NY: a[1] <= cfg_data;
          REG_SRC_NZ: a[2] <= cfg_data;
          REG_DST_NX: b[0] <= cfg_data;
          REG_DST_NY: b[1] <= cfg_data;
          REG_DST_NZ: b[2] <= cfg_data;
          default: ;
        endcase
      end
      acc <= acc_next;
      if (cfg_hit) begin
        state    <= ST_MUL;
        pc       <= '0;
        launched <= 1'b0;
      end else begin
        unique case (state)
          ST_IDLE: ;
          ST_MUL: begin
            pc <= pc + 5'd1;
            unique case (pc)
              5'd1:  u[0] <= acc_next[MUL_W-1:0];
              5'd3:  u[1] <= acc_next[MUL_W-1:0];
              5'd5:  u[2] <= acc_next[MUL_W-1:0];
              5'd8:  dot  <= acc_next[MUL_W-1:0];
              5'd11: la   <= acc_next[MUL_W-1:0];
              5'd14: lb   <= acc_next[MUL_W-1:0];
              5'd15: lsq  <= acc_next[SQ_W-1:0];
              5'd18: lusq <= acc_next[SQ_W-1:0];
              default: ;
            endcase
            if (pc == 5'd18) begin
              if (u[0] == '0 && u[1] == '0 && u[2] == '0) begin
                mat   <= ident_mat();
                degen <= 1'b1;
                state <= ST_IDLE;
              end else begin
                degen    <= 1'b0;
                launched <= 1'b0;
                state    <= ST_SQL;
              end
            end
          end
          ST_SQL: begin
            if (!launched) launched <= 1'b1;
            else if (!sq_busy) begin
              n        <= sq_root;
              launched <= 1'b0;
              state    <= ST_SQU;
            end
          end
          ST_SQU: begin
            if (!launched) launched <= 1'b1;
            else if (!sq_busy) begin
              m        <= sq_root;
              launched <= 1'b0;
              dsel     <= '0;
              state    <= ST_DIV;
            end
          end
          ST_DIV: begin
            if (!launched) launched <= 1'b1;
            else if (!dv_busy) begin
              unique case (dsel)
                3'd0: c    <= dv_quot;
                3'd1: s    <= dv_quot;
                3'd2: k[0] <= dv_quot;
                3'd3: k[1] <= dv_quot;
                3'd4: k[2] <= dv_quot;
                default: ;
              endcase
              launched <= 1'b0;
              if (dsel == 3'd4) begin
                pc    <= '0;
                state <= ST_SK;
              end else begin
                dsel <= dsel + 3'd1;
              end
            end
          end
          ST_SK: begin
            sk[pc[1:0]] <= rp[SK_W-1:0];
            if (pc == 5'd2) begin
              mi    <= '0;
              mj    <= '0;
              mb    <= 1'b0;
              state <= ST_MAT;
            end else begin
              pc <= pc + 5'd1;
            end
          end
          ST_MAT: begin
            if (!mb) begin
              t  <= rp[SK_W-1:0];
              mb <= 1'b1;
            end else begin
              mat[eidx] <= sat_mat(ent);
              mb        <= 1'b0;
              if (mj == 2'd2) begin
                mj <= '0;
                if (mi == 2'd2) state <= ST_IDLE;
                else            mi    <= mi + 2'd1;
              end else begin
                mj <= mj + 2'd1;
              end
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  assign status.busy  = (state != ST_IDLE);
  assign status.degen = degen;

endmodule

[rtl/pran_xform.sv]
// Four-stage pipeline: matrix times point, round, saturate.
`timescale 1ns / 1ps
module pran_xform (
  input  logic                   clk,
  input  logic                   rst,
  input  pran_pkg::mat_t         mat,
  input  pran_pkg::bld_status_t  status,
  pran_pt_if.sink                points,
  pran_res_if.source             results
);
  import pran_pkg::*;

  localparam int P_W = MAT_W + COORD_BITS;
  localparam int S_W = P_W + 2;
  localparam int R_W = S_W - FRAC;

  logic en;
  logic v1, v2, v3, v4;
  logic d1, d2, d3, d4;
  logic signed [COORD_BITS-1:0] p1 [3];
  logic signed [P_W-1:0]        pr [MAT_N];
  logic signed [S_W-1:0]        sm [3];
  logic signed [R_W-1:0]        rs [3];
  logic signed [COORD_BITS-1:0] o  [3];

  assign en           = !v4 || results.ready;
  assign points.ready = en && !status.busy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[i] = S_W'(pr[3*i]) + S_W'(pr[3*i+1]) + S_W'(pr[3*i+2])
            + $signed(S_W'(1) << (FRAC - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= points.valid && !status.busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= points.in_x;
      p1[1] <= points.in_y;
      p1[2] <= points.in_z;
      d1    <= status.degen;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          pr[3*i+j] <= $signed(mat[3*i+j]) * p1[j];
      d2 <= d1;
      for (int i = 0; i < 3; i++) rs[i] <= sm[i][S_W-1:FRAC];
      d3 <= d2;
      for (int i = 0; i < 3; i++) begin
        if (&rs[i][R_W-1:COORD_BITS-1] || ~|rs[i][R_W-1:COORD_BITS-1])
          o[i] <= rs[i][COORD_BITS-1:0];
        else if (rs[i][R_W-1])
          o[i] <= {1'b1, {(COORD_BITS-1){1'b0}}};
        else
          o[i] <= {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      d4 <= d3;
    end
  end

  assign results.valid      = v4;
  assign results.out_x      = o[0];
  assign results.out_y      = o[1];
  assign results.out_z      = o[2];
  assign results.degenerate = d4;

endmodule
